// ===== rtl/core/ddgs_pkg.sv =====
// shared types, constants and functions for the goal steering block
package ddgs_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int POS_WIDTH    = 24;
    localparam int ZW           = 26;

    localparam logic signed [15:0] HALF_TURN = 16'sd23040;
    localparam logic signed [19:0] FULL_TURN = 20'sd46080;
    localparam logic signed [15:0] QUARTER   = 16'sd11520;
    localparam logic [12:0]        PROP_FULL = 13'd5760;
    localparam logic [16:0]        SPEED_MAX = 17'd65535;
    localparam logic signed [15:0] UNIT_14   = 16'sd16384;
    localparam logic [31:0]        CORDIC_K  = 32'd652032874;
    localparam int                 QUO_BITS  = 18;

    // n / 5760 as ((n >> 7) * RECIP_45) >> 29, exact for n below 2^30
    localparam int                 PROP_SHIFT  = 7;
    localparam logic [23:0]        RECIP_45    = 24'd11930465;
    localparam int                 RECIP_SHIFT = 29;

    localparam logic [1:0] REG_SPEED = 2'd0;
    localparam logic [1:0] REG_STOP  = 2'd1;
    localparam logic [1:0] REG_THR   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_C, ST_MUL_S, ST_POS_Y, ST_ROT, ST_VST, ST_VEC, ST_DECIDE,
        ST_SQ_X, ST_SQ_Y, ST_SQ_L, ST_CMP, ST_PMUL, ST_DIV_INIT, ST_DIV, ST_FIN
    } t_state;

    typedef struct packed {
        logic start;
        logic vector;
    } t_cordic_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    function automatic logic signed [22:0] atan_q16(input logic [4:0] idx);
        logic signed [22:0] v;
        unique case (idx)
            5'd0:  v = 23'sd2949120;
            5'd1:  v = 23'sd1740967;
            5'd2:  v = 23'sd919879;
            5'd3:  v = 23'sd466945;
            5'd4:  v = 23'sd234379;
            5'd5:  v = 23'sd117304;
            5'd6:  v = 23'sd58666;
            5'd7:  v = 23'sd29335;
            5'd8:  v = 23'sd14668;
            5'd9:  v = 23'sd7334;
            5'd10: v = 23'sd3667;
            5'd11: v = 23'sd1833;
            5'd12: v = 23'sd917;
            5'd13: v = 23'sd458;
            5'd14: v = 23'sd229;
            5'd15: v = 23'sd115;
            5'd16: v = 23'sd57;
            5'd17: v = 23'sd29;
            5'd18: v = 23'sd14;
            5'd19: v = 23'sd7;
            5'd20: v = 23'sd4;
            5'd21: v = 23'sd2;
            5'd22: v = 23'sd1;
            default: v = 23'sd0;
        endcase
        return v;
    endfunction

    // one wrap step either way covers every sum this block forms
    function automatic logic signed [15:0] wrap_angle(input logic signed [19:0] a);
        logic signed [19:0] r;
        if (a < -20'(HALF_TURN)) begin
            r = a + FULL_TURN;
        end else if (a > 20'(HALF_TURN)) begin
            r = a - FULL_TURN;
        end else begin
            r = a;
        end
        return r[15:0];
    endfunction

endpackage

// ===== rtl/core/diff_drive_goal_steering.sv =====
// top level of the differential drive go-to-goal steering block
//
// input beats on s_axis: kind in tuser (0 odometry tick, 1 set target),
// wheel travels and target offsets in tdata. one result beat per input
// beat on m_axis with wheel speeds, robot and goal position, bearing error.
// registers drive_speed, stop_distance, turn_threshold on the apb port at
// byte addresses 0, 4 and 8.
// a set-target beat goes from idle straight to the result state.
// a tick runs the heading and position states, the shared cordic unit
// for the facing and again for the bearing, and a decide state; 3
// multiplies and a compare for the stop test follow, then one multiply
// for the proportional product and a reciprocal multiply for the divide
// by 5760. turning in place leaves for the result state at decide,
// stopping at the compare and steering after the divide. the result is
// registered in the result state once the output register is free, then
// the sequencer goes idle and takes the next beat. s_axis_tready is high only while the sequencer is idle.
// the result sits in an output register; the next beat is taken while it
// waits, and that beat's result waits until the receiver takes the first.
// reset clears position, target and heading, sets the facing to zero
// degrees and loads the register defaults.
module diff_drive_goal_steering #(
    parameter int CORDIC_STEPS = ddgs_pkg::CORDIC_STEPS,
    parameter int POS_WIDTH    = ddgs_pkg::POS_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [79:0]   s_axis_tdata,   // left_travel, right_travel, target_dx, target_dy
    input  logic          s_axis_tuser,   // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [151:0]  m_axis_tdata,   // first_speed, second_speed, robot_x, robot_y,
                                          // goal_x, goal_y, bearing_error, zero fill
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int PW = POS_WIDTH;
    localparam int CW = (PW + 11 > 34) ? PW + 11 : 34;
    localparam int MW = (PW + 1 > 25) ? PW + 1 : 25;
    localparam int ZW = ddgs_pkg::ZW;
    localparam int QB = ddgs_pkg::QUO_BITS;

    ddgs_pkg::t_state       r_state, n_state;
    ddgs_pkg::t_cordic_cmd  cmd;
    ddgs_pkg::t_cordic_stat stat;

    logic [15:0]            r_speed;
    logic [11:0]            r_stop;
    logic [5:0]             r_thr;
    logic signed [PW-1:0]   r_pos_x, r_pos_y, r_tgt_x, r_tgt_y, r_dx, r_dy;
    logic signed [15:0]     r_heading, r_cos, r_sin, r_err, r_off;
    logic signed [16:0]     r_sum, r_first, r_second;
    logic                   r_neg, r_zero, r_qneg;
    logic signed [2*MW-1:0] r_prod;
    logic [2*MW:0]          r_acc;
    logic [31:0]            r_rem;
    logic [QB-1:0]          r_quo;
    logic                   r_k;
    logic                   r_prop;
    logic                   r_m_valid;
    logic [151:0]           r_m_data;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [CW-1:0]   cx, cy, vx, vy, xr, yr;
    logic signed [ZW-1:0]   cz, rz;
    logic signed [15:0]     in_left, in_right, hfold, cos_n, sin_n, atan_v, err_n, thr;
    logic signed [16:0]     hsum;
    logic signed [PW:0]     ax, ay;
    logic                   s_acc, cfg_wr, out_free;
    logic signed [16:0]     qval;
    logic [16:0]            qsat;

    function automatic logic signed [15:0] clamp14(input logic signed [CW-1:0] v);
        logic signed [15:0] r;
        if (v > CW'(ddgs_pkg::UNIT_14)) begin
            r = ddgs_pkg::UNIT_14;
        end else if (v < -CW'(ddgs_pkg::UNIT_14)) begin
            r = -ddgs_pkg::UNIT_14;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign in_left  = s_axis_tdata[15:0];
    assign in_right = s_axis_tdata[31:16];
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= 16'd100;
            r_stop  <= 12'd10;
            r_thr   <= 6'd5;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                ddgs_pkg::REG_SPEED: r_speed <= pwdata[15:0];
                ddgs_pkg::REG_STOP:  r_stop  <= pwdata[11:0];
                ddgs_pkg::REG_THR:   r_thr   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ddgs_pkg::REG_SPEED: prdata = {16'd0, r_speed};
            ddgs_pkg::REG_STOP:  prdata = {20'd0, r_stop};
            ddgs_pkg::REG_THR:   prdata = {26'd0, r_thr};
            default:             prdata = 32'd0;
        endcase
    end

    ddgs_cordic #(.STEPS(CORDIC_STEPS), .CW(CW)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_x     (cx),
        .i_y     (cy),
        .i_z     (cz),
        .o_stat  (stat),
        .o_x     (vx),
        .o_y     (vy),
        .o_z     (rz)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddgs_pkg::ST_IDLE:     if (s_acc) n_state = s_axis_tuser ? ddgs_pkg::ST_FIN
                                                                     : ddgs_pkg::ST_MUL_C;
            ddgs_pkg::ST_MUL_C:    n_state = ddgs_pkg::ST_MUL_S;
            ddgs_pkg::ST_MUL_S:    n_state = ddgs_pkg::ST_POS_Y;
            ddgs_pkg::ST_POS_Y:    n_state = ddgs_pkg::ST_ROT;
            ddgs_pkg::ST_ROT:      if (stat.done) n_state = ddgs_pkg::ST_VST;
            ddgs_pkg::ST_VST:      n_state = ddgs_pkg::ST_VEC;
            ddgs_pkg::ST_VEC:      if (stat.done) n_state = ddgs_pkg::ST_DECIDE;
            ddgs_pkg::ST_DECIDE:   n_state = (r_err < -thr || r_err > thr) ? ddgs_pkg::ST_FIN
                                                                           : ddgs_pkg::ST_SQ_X;
            ddgs_pkg::ST_SQ_X:     n_state = ddgs_pkg::ST_SQ_Y;
            ddgs_pkg::ST_SQ_Y:     n_state = ddgs_pkg::ST_SQ_L;
            ddgs_pkg::ST_SQ_L:     n_state = ddgs_pkg::ST_CMP;
            ddgs_pkg::ST_CMP:      n_state = (r_acc < (2*MW+1)'(r_prod)) ? ddgs_pkg::ST_FIN
                                                                         : ddgs_pkg::ST_PMUL;
            ddgs_pkg::ST_PMUL:     n_state = ddgs_pkg::ST_DIV_INIT;
            ddgs_pkg::ST_DIV_INIT: n_state = ddgs_pkg::ST_DIV;
            ddgs_pkg::ST_DIV:      if (!r_k) n_state = ddgs_pkg::ST_FIN;
            ddgs_pkg::ST_FIN:      if (out_free) n_state = ddgs_pkg::ST_IDLE;
            default:               n_state = ddgs_pkg::ST_IDLE;
        endcase
    end

    // control outputs and operand selection
    always_comb begin
        s_axis_tready = (r_state == ddgs_pkg::ST_IDLE);
        cmd.start     = (r_state == ddgs_pkg::ST_POS_Y) || (r_state == ddgs_pkg::ST_VST);
        cmd.vector    = (r_state == ddgs_pkg::ST_VST);
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ddgs_pkg::ST_MUL_C: begin
                mul_a = MW'(r_cos);
                mul_b = MW'(r_sum);
            end
            ddgs_pkg::ST_MUL_S: begin
                mul_a = MW'(r_sin);
                mul_b = MW'(r_sum);
            end
            ddgs_pkg::ST_SQ_X: begin
                mul_a = MW'(ax);
                mul_b = MW'(ax);
            end
            ddgs_pkg::ST_SQ_Y: begin
                mul_a = MW'(ay);
                mul_b = MW'(ay);
            end
            ddgs_pkg::ST_SQ_L: begin
                mul_a = MW'({r_stop, 8'd0});
                mul_b = MW'({r_stop, 8'd0});
            end
            ddgs_pkg::ST_PMUL: begin
                mul_a = MW'({1'b0, r_speed});
                mul_b = (r_err > 0) ? MW'(signed'(16'(ddgs_pkg::PROP_FULL)) - r_err)
                                    : MW'(signed'(16'(ddgs_pkg::PROP_FULL)) + r_err);
            end
            ddgs_pkg::ST_DIV: if (r_k) begin
                mul_a = MW'(signed'({1'b0, r_rem[31:ddgs_pkg::PROP_SHIFT]}));
                mul_b = MW'(signed'({1'b0, ddgs_pkg::RECIP_45}));
            end
            default: ;
        endcase
    end

    // datapath helpers
    always_comb begin
        thr   = 16'({r_thr, 7'd0});
        hsum  = 17'(r_heading) + 17'(r_heading > ddgs_pkg::QUARTER ? -ddgs_pkg::HALF_TURN
                              : (r_heading < -ddgs_pkg::QUARTER ? ddgs_pkg::HALF_TURN : 16'sd0));
        hfold = hsum[15:0];
        cx = '0;
        cy = '0;
        cz = '0;
        if (r_state == ddgs_pkg::ST_POS_Y) begin
            cx = CW'(signed'({1'b0, ddgs_pkg::CORDIC_K}));
            cz = ZW'(hfold) <<< 9;
        end else begin
            cx = CW'(r_dx) <<< 8;
            cy = CW'(r_dy) <<< 8;
            if (r_dx < 0) begin
                cx = -cx;
                cy = -cy;
            end
        end
        xr    = (vx + CW'(32768)) >>> 16;
        yr    = (vy + CW'(32768)) >>> 16;
        cos_n = clamp14(r_neg ? -xr : xr);
        sin_n = clamp14(r_neg ? -yr : yr);
        atan_v = r_zero ? 16'sd0
               : ddgs_pkg::wrap_angle(20'(r_off) + 20'((rz + ZW'(256)) >>> 9));
        err_n = ddgs_pkg::wrap_angle(20'(atan_v) - 20'(r_heading) + 20'(ddgs_pkg::HALF_TURN));
        ax    = (r_dx < 0) ? -(PW+1)'(r_dx) : (PW+1)'(r_dx);
        ay    = (r_dy < 0) ? -(PW+1)'(r_dy) : (PW+1)'(r_dy);
        qsat  = (r_quo > QB'(ddgs_pkg::SPEED_MAX)) ? ddgs_pkg::SPEED_MAX : 17'(r_quo);
        qval  = r_qneg ? -signed'(qsat) : signed'(qsat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddgs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // navigation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_tgt_x   <= '0;
            r_tgt_y   <= '0;
            r_heading <= '0;
            r_cos     <= ddgs_pkg::UNIT_14;
            r_sin     <= '0;
        end else begin
            unique case (r_state)
                ddgs_pkg::ST_IDLE: if (s_acc) begin
                    if (s_axis_tuser) begin
                        r_tgt_x <= r_pos_x + PW'(signed'(s_axis_tdata[55:32]));
                        r_tgt_y <= r_pos_y + PW'(signed'(s_axis_tdata[79:56]));
                    end else begin
                        r_heading <= ddgs_pkg::wrap_angle(20'(r_heading)
                                     + 20'((17'(in_right) - 17'(in_left)) >>> 1));
                    end
                end
                ddgs_pkg::ST_MUL_S: r_pos_x <= r_pos_x + PW'(r_prod >>> 15);
                ddgs_pkg::ST_POS_Y: r_pos_y <= r_pos_y + PW'(r_prod >>> 15);
                ddgs_pkg::ST_ROT: if (stat.done) begin
                    r_cos <= cos_n;
                    r_sin <= sin_n;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            ddgs_pkg::ST_IDLE: begin
                r_sum    <= 17'(in_left) + 17'(in_right);
                r_first  <= '0;
                r_second <= '0;
                r_err    <= '0;
            end
            ddgs_pkg::ST_POS_Y: r_neg <= (r_heading > ddgs_pkg::QUARTER)
                                      || (r_heading < -ddgs_pkg::QUARTER);
            ddgs_pkg::ST_ROT: begin
                r_dx <= r_pos_x - r_tgt_x;
                r_dy <= r_pos_y - r_tgt_y;
            end
            ddgs_pkg::ST_VST: begin
                r_zero <= (r_dx == 0) && (r_dy == 0);
                r_off  <= (r_dx >= 0) ? 16'sd0
                        : ((r_dy >= 0) ? ddgs_pkg::HALF_TURN : -ddgs_pkg::HALF_TURN);
            end
            ddgs_pkg::ST_VEC: if (stat.done) r_err <= err_n;
            ddgs_pkg::ST_DECIDE: begin
                if (r_err < -thr) begin
                    r_first  <= 17'({1'b0, r_speed});
                    r_second <= -17'({1'b0, r_speed});
                end else begin
                    r_first  <= -17'({1'b0, r_speed});
                    r_second <= 17'({1'b0, r_speed});
                end
            end
            ddgs_pkg::ST_SQ_Y: r_acc <= (2*MW+1)'(r_prod);
            ddgs_pkg::ST_SQ_L: r_acc <= r_acc + (2*MW+1)'(r_prod);
            ddgs_pkg::ST_CMP: begin
                r_first  <= '0;
                r_second <= '0;
            end
            ddgs_pkg::ST_DIV_INIT: begin
                r_qneg <= r_prod < 0;
                r_rem  <= (r_prod < 0) ? 32'(-r_prod) : 32'(r_prod);
                r_k    <= 1'b1;
            end
            ddgs_pkg::ST_DIV: begin
                r_k <= 1'b0;
                if (!r_k) begin
                    r_quo <= QB'(r_prod >>> ddgs_pkg::RECIP_SHIFT);
                    if (r_err > 0) begin
                        r_first  <= '0;
                        r_second <= 17'({1'b0, r_speed});
                    end else begin
                        r_first  <= 17'({1'b0, r_speed});
                        r_second <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // the proportional wheel takes the quotient until the result is stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop <= 1'b0;
        end else if ((r_state == ddgs_pkg::ST_DIV) && !r_k) begin
            r_prop <= 1'b1;
        end else if (r_state == ddgs_pkg::ST_IDLE) begin
            r_prop <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ddgs_pkg::ST_FIN && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ddgs_pkg::ST_FIN && out_free) begin
            r_m_data <= {6'd0, r_err, 24'(r_tgt_y), 24'(r_tgt_x), 24'(r_pos_y), 24'(r_pos_x),
                         (r_prop && r_err <= 0) ? qval : r_second,
                         (r_prop && r_err > 0) ? qval : r_first};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !stat.busy)
        else $error("input ready while cordic busy");
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading >= -ddgs_pkg::HALF_TURN && r_heading <= ddgs_pkg::HALF_TURN)
        else $error("heading out of range");
    a_facing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cos >= -ddgs_pkg::UNIT_14 && r_cos <= ddgs_pkg::UNIT_14
        && r_sin >= -ddgs_pkg::UNIT_14 && r_sin <= ddgs_pkg::UNIT_14)
        else $error("facing out of range");
    a_prop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prop |-> (r_state == ddgs_pkg::ST_FIN || r_state == ddgs_pkg::ST_IDLE))
        else $error("proportional flag outside result cycle");
`endif

endmodule

// ===== rtl/core/ddgs_cordic.sv =====
// shared cordic micro-rotation unit, one step per cycle
module ddgs_cordic #(
    parameter int STEPS = ddgs_pkg::CORDIC_STEPS,
    parameter int CW    = 34
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ddgs_pkg::t_cordic_cmd        i_cmd,
    input  logic signed [CW-1:0]         i_x,
    input  logic signed [CW-1:0]         i_y,
    input  logic signed [ddgs_pkg::ZW-1:0] i_z,
    output ddgs_pkg::t_cordic_stat       o_stat,
    output logic signed [CW-1:0]         o_x,
    output logic signed [CW-1:0]         o_y,
    output logic signed [ddgs_pkg::ZW-1:0] o_z
);

    localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic signed [CW-1:0]           r_x, r_y, n_x, n_y, xs, ys;
    logic signed [ddgs_pkg::ZW-1:0] r_z, n_z, ang;
    logic [SW-1:0]                  r_step;
    logic                           r_busy, r_done, r_vec, ccw;

    always_comb begin
        xs  = r_x >>> r_step;
        ys  = r_y >>> r_step;
        ang = ddgs_pkg::ZW'(ddgs_pkg::atan_q16(5'(r_step)));
        ccw = r_vec ? (r_y < 0) : (r_z >= 0);
        if (ccw) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - ang;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_cmd.vector;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== tb/diff_drive_goal_steering_test.sv =====
// testbench for the go-to-goal steering block: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module diff_drive_goal_steering_test;

    typedef struct {
        logic signed [16:0] first;
        logic signed [16:0] second;
        logic signed [23:0] rx;
        logic signed [23:0] ry;
        logic signed [23:0] gx;
        logic signed [23:0] gy;
        logic signed [15:0] err;
    } t_steer;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint ATAN_DEG[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [79:0]   s_axis_tdata = '0;   // left_travel, right_travel, target_dx, target_dy
    logic          s_axis_tuser = 1'b0; // kind
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [151:0]  m_axis_tdata;        // first, second, robot_x, robot_y, goal_x, goal_y, error
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    diff_drive_goal_steering u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_steer steer_q[$];
    int     errors = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     quiet_cycles = 0;

    // predictor state
    longint speed_reg, stop_reg, thr_reg;
    longint px, py, gx, gy, hdg, fcos, fsin;

    function automatic longint wrap24(longint v);
        logic signed [23:0] t;
        t = v[23:0];
        return longint'(t);
    endfunction

    function automatic longint wrap_deg(longint a);
        while (a < -23040) a += 46080;
        while (a > 23040) a -= 46080;
        return a;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint sat_speed(longint v);
        if (v > 65535) return 65535;
        if (v < -65535) return -65535;
        return v;
    endfunction

    function automatic void rotate_facing();
        longint z, x, y, xs, ys;
        bit flip;
        z = hdg * 512;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 90 * 65536) begin
            z -= 180 * 65536;
            flip = 1;
        end else if (z < -90 * 65536) begin
            z += 180 * 65536;
            flip = 1;
        end
        for (int i = 0; i < ddgs_pkg::CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_DEG[i];
            end else begin
                x += ys; y -= xs; z += ATAN_DEG[i];
            end
        end
        x = round_shift(x, 16);
        y = round_shift(y, 16);
        if (flip) begin
            x = -x; y = -y;
        end
        fcos = clamp_unit(x);
        fsin = clamp_unit(y);
    endfunction

    function automatic longint bearing_of(longint dy, longint dx);
        longint x, y, z, off, xs, ys;
        if (dx == 0 && dy == 0) return 0;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        off = 0;
        if (x < 0) begin
            off = (y >= 0) ? 23040 : -23040;
            x = -x; y = -y;
        end
        for (int i = 0; i < ddgs_pkg::CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_DEG[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_DEG[i];
            end
        end
        return wrap_deg(off + round_shift(z, 9));
    endfunction

    function automatic t_steer predict_steer(logic kind, logic [79:0] d);
        t_steer r;
        longint first, second, err, l, rt, sum, dx, dy, ax, ay, lim, thr;
        logic signed [15:0] l16, r16;
        logic signed [23:0] ox, oy;
        first = 0; second = 0; err = 0;
        l16 = d[15:0]; r16 = d[31:16]; ox = d[55:32]; oy = d[79:56];
        if (kind) begin
            gx = wrap24(px + longint'(ox));
            gy = wrap24(py + longint'(oy));
        end else begin
            l = l16; rt = r16; sum = l + rt;
            thr = thr_reg * 128;
            hdg = wrap_deg(hdg + ((rt - l) >>> 1));
            px = wrap24(px + ((fcos * sum) >>> 15));
            py = wrap24(py + ((fsin * sum) >>> 15));
            rotate_facing();
            dx = wrap24(px - gx);
            dy = wrap24(py - gy);
            err = wrap_deg(bearing_of(dy, dx) - hdg + 23040);
            if (err < -thr) begin
                first = speed_reg; second = -speed_reg;
            end else if (err > thr) begin
                first = -speed_reg; second = speed_reg;
            end else begin
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                lim = stop_reg * 256;
                if (ax * ax + ay * ay < lim * lim) begin
                    first = 0; second = 0;
                end else if (err > 0) begin
                    first = sat_speed(speed_reg * (5760 - err) / 5760);
                    second = speed_reg;
                end else begin
                    first = speed_reg;
                    second = sat_speed(speed_reg * (5760 + err) / 5760);
                end
            end
        end
        r.first = first[16:0]; r.second = second[16:0];
        r.rx = px[23:0]; r.ry = py[23:0]; r.gx = gx[23:0]; r.gy = gy[23:0];
        r.err = err[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_steer want, got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.first = m_axis_tdata[16:0];
            got.second = m_axis_tdata[33:17];
            got.rx = m_axis_tdata[57:34];
            got.ry = m_axis_tdata[81:58];
            got.gx = m_axis_tdata[105:82];
            got.gy = m_axis_tdata[129:106];
            got.err = m_axis_tdata[145:130];
            if (steer_q.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                want = steer_q.pop_front();
                if (got.first !== want.first) report_mismatch("first_speed", got.first, want.first);
                if (got.second !== want.second)
                    report_mismatch("second_speed", got.second, want.second);
                if (got.rx !== want.rx) report_mismatch("robot_x", got.rx, want.rx);
                if (got.ry !== want.ry) report_mismatch("robot_y", got.ry, want.ry);
                if (got.gx !== want.gx) report_mismatch("goal_x", got.gx, want.gx);
                if (got.gy !== want.gy) report_mismatch("goal_y", got.gy, want.gy);
                if (got.err !== want.err) report_mismatch("bearing_error", got.err, want.err);
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("diff_drive_goal_steering_test failed");
            $finish;
        end
    end

    task automatic send_beat(logic kind, logic [79:0] d);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        steer_q.push_back(predict_steer(kind, d));
    endtask

    task automatic send_tick(int l, int r);
        send_beat(1'b0, {16'($urandom()), $urandom(), 16'(r), 16'(l)});
    endtask

    task automatic send_target(int dx, int dy);
        send_beat(1'b1, {24'(dy), 24'(dx), $urandom()});
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (steer_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            ddgs_pkg::REG_SPEED: speed_reg = val[15:0];
            ddgs_pkg::REG_STOP:  stop_reg = val[11:0];
            ddgs_pkg::REG_THR:   thr_reg = val[5:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int spd, int stp, int thr);
        drain();
        write_reg(ddgs_pkg::REG_SPEED, spd);
        write_reg(ddgs_pkg::REG_STOP, stp);
        write_reg(ddgs_pkg::REG_THR, thr);
    endtask

    task automatic test_directed();
        send_tick(0, 0);
        send_target(0, 0);
        send_tick(0, 0);
        send_target(2560, 0);
        send_tick(256, 256);
        send_tick(-32768, 32767);
        send_tick(32767, -32768);
        send_tick(32767, 32767);
        send_tick(-32768, -32768);
        send_target(-8388608, 8388607);
        send_tick(100, 300);
        send_target(8388607, -8388608);
        send_tick(-500, 500);
        send_target(1000, 20);
        send_tick(10, 10);
        set_regs(65535, 0, 63);
        send_tick(300, 100);
        send_target(-3000, 400);
        send_tick(50, 60);
        set_regs(0, 4095, 0);
        send_tick(5, 5);
        send_target(0, 0);
        send_tick(0, 0);
        set_regs(100, 10, 45);
        send_target(-5000, -4000);
        send_tick(200, 220);
    endtask

    task automatic test_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_tick(int'($urandom_range(1600)) - 400, int'($urandom_range(1600)) - 400);
            end else if (pick < 85) begin
                send_target(int'($urandom_range(40000)) - 20000,
                            int'($urandom_range(40000)) - 20000);
            end else if (pick < 95) begin
                send_tick(int'($urandom()), int'($urandom()));
            end else begin
                send_beat(1'b1, {16'($urandom()), $urandom(), $urandom()});
            end
        end
    endtask

    task automatic test_phases();
        int pcts[4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{13, 13}};
        for (int p = 0; p < 8; p++) begin
            set_regs($urandom_range(65535), $urandom_range(3) == 0 ? 4095 : $urandom_range(60),
                     $urandom_range(63));
            idle_pct = pcts[p % 4][0];
            stall_pct = pcts[p % 4][1];
            test_random(200);
        end
    endtask

    initial begin
        speed_reg = 100; stop_reg = 10; thr_reg = 5;
        px = 0; py = 0; gx = 0; gy = 0; hdg = 0; fcos = 16384; fsin = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_phases();
        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (errors == 0) begin
            $display("diff_drive_goal_steering_test passed");
        end else begin
            $display("diff_drive_goal_steering_test failed");
        end
        $finish;
    end

endmodule

// ===== diff_drive_goal_steering.f =====
rtl/core/ddgs_pkg.sv
rtl/core/ddgs_cordic.sv
rtl/core/diff_drive_goal_steering.sv
tb/diff_drive_goal_steering_test.sv
